// ===== rtl/sha1md_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 message digest package
// Shared types, constants and round helper functions for the digest block.
// ----------------------------------------------------------------------------
package sha1md_pkg;

  // Chaining value: word 0 is h0
  typedef logic [4:0][31:0] chain_t;

  // Initial hash constants
  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [31:0] H2_INIT = 32'h98BADCFE;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

  // Round constants, one per group of twenty rounds
  localparam logic [31:0] K_0 = 32'h5A827999;
  localparam logic [31:0] K_1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_3 = 32'hCA62C1D6;

  // Padding marker byte and the byte position where the length field starts
  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;

  // Round bookkeeping
  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [6:0] ROUND_G1   = 7'd20;
  localparam logic [6:0] ROUND_G2   = 7'd40;
  localparam logic [6:0] ROUND_G3   = 7'd60;

  // Index of the final digest word
  localparam logic [2:0] LAST_WORD_IDX = 3'd4;

  // Control from the sequencer to the compression unit
  typedef struct packed {
    logic       shift_en;    // shift one byte into the block register
    logic [7:0] shift_byte;  // byte to shift in
    logic       start;       // begin compressing the block
    logic       chain_init;  // return the chaining value to the initial constants
  } core_ctrl_t;

  // Status from the compression unit
  typedef struct packed {
    logic busy;  // rounds in progress
    logic done;  // chaining value updated this cycle
  } core_stat_t;

  function automatic chain_t chain_init_value();
    chain_t c;
    c[0] = H0_INIT;
    c[1] = H1_INIT;
    c[2] = H2_INIT;
    c[3] = H3_INIT;
    c[4] = H4_INIT;
    return c;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  // Round function and constant, selected by round number
  function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (rnd < ROUND_G1) begin
      f = (b & c) | (~b & d);
    end else if (rnd < ROUND_G2) begin
      f = b ^ c ^ d;
    end else if (rnd < ROUND_G3) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] rnd);
    logic [31:0] k;
    if (rnd < ROUND_G1) begin
      k = K_0;
    end else if (rnd < ROUND_G2) begin
      k = K_1;
    end else if (rnd < ROUND_G3) begin
      k = K_2;
    end else begin
      k = K_3;
    end
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sha1_message_digest.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 message digest
// Streams a message in one byte per request and returns the five digest words.
// ----------------------------------------------------------------------------
// Block: the 64th byte of a block starts a compression of 80 rounds on the
//   shared round unit, then the working variables are folded into the chain.
// End of message: padding and length bytes go in at one per cycle while no
//   block compresses (up to 72 over one or two blocks, with a pause in the pad
//   state before the length), each full block adds a compression, then five
//   output words. No byte is accepted while a block compresses.
// Reset: rst (synchronous) clears the byte count and bit length, restores the
//   initial chaining value and returns the sequencer to idle with no word pending.
// ----------------------------------------------------------------------------
module sha1_message_digest (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // [7:0] in_byte
  input  wire         s_tuser,   // [0] byte_valid
  input  wire         s_tlast,   // msg_end
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, [39:35] zero
  output logic        m_tlast    // last_word
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PAD  = 5'b00010,
    ST_LEN  = 5'b00100,
    ST_COMP = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t                 state;
  state_t                 ret;
  logic [5:0]             fill;
  logic [63:0]            bits;
  logic                   pad_first;
  logic [2:0]             out_idx;
  logic                   in_acc;
  logic                   pad_done;
  sha1md_pkg::core_ctrl_t ctrl;
  sha1md_pkg::core_stat_t stat;
  sha1md_pkg::chain_t     chain;

  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign pad_done = !pad_first && (fill == sha1md_pkg::LEN_START);

  // Feed bytes to the block register and start compression on a full block
  always_comb begin
    ctrl.shift_en   = 1'b0;
    ctrl.shift_byte = s_tdata;
    case (state)
      ST_IDLE: begin
        ctrl.shift_en = in_acc && s_tuser;
      end
      ST_PAD: begin
        ctrl.shift_en   = !pad_done;
        ctrl.shift_byte = pad_first ? sha1md_pkg::PAD_BYTE : 8'h00;
      end
      ST_LEN: begin
        ctrl.shift_en   = 1'b1;
        ctrl.shift_byte = bits[63:56];
      end
      default: begin
        ctrl.shift_en = 1'b0;
      end
    endcase
    ctrl.start      = ctrl.shift_en && (&fill);
    ctrl.chain_init = (state == ST_OUT) && m_tready && (out_idx == sha1md_pkg::LAST_WORD_IDX);
  end

  // Message sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ret       <= ST_IDLE;
      fill      <= '0;
      bits      <= '0;
      pad_first <= 1'b0;
      out_idx   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            pad_first <= 1'b1;
            if (s_tuser) begin
              fill <= fill + 6'd1;
              bits <= bits + 64'd8;
            end
            if (s_tuser && (&fill)) begin
              state <= ST_COMP;
              ret   <= s_tlast ? ST_PAD : ST_IDLE;
            end else if (s_tlast) begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          if (pad_done) begin
            state <= ST_LEN;
          end else begin
            pad_first <= 1'b0;
            fill      <= fill + 6'd1;
            if (&fill) begin
              state <= ST_COMP;
              ret   <= ST_PAD;
            end
          end
        end
        ST_LEN: begin
          bits <= bits << 8;
          fill <= fill + 6'd1;
          if (&fill) begin
            state   <= ST_COMP;
            ret     <= ST_OUT;
            out_idx <= '0;
          end
        end
        ST_COMP: begin
          if (stat.done) begin
            state <= ret;
          end
        end
        ST_OUT: begin
          if (m_tready) begin
            if (out_idx == sha1md_pkg::LAST_WORD_IDX) begin
              state   <= ST_IDLE;
              out_idx <= '0;
              bits    <= '0;
              fill    <= '0;
            end else begin
              out_idx <= out_idx + 3'd1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Digest words drive the output straight from the chaining register
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata  = {5'b0, out_idx, chain[out_idx]};
  assign m_tlast  = (out_idx == sha1md_pkg::LAST_WORD_IDX);

  sha1md_core u_core (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .stat  (stat),
    .chain (chain)
  );

  a_done_in_comp : assert property (@(posedge clk) disable iff (rst)
    stat.done |-> state == ST_COMP)
    else $error("compression finished outside the wait state");

  a_len_aligned : assert property (@(posedge clk) disable iff (rst)
    state == ST_LEN |-> fill >= sha1md_pkg::LEN_START)
    else $error("length field misaligned");

  a_back_to_idle : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> state == ST_IDLE && fill == 6'd0 && bits == 64'd0)
    else $error("message state not cleared after digest");

  a_idle_when_rounds : assert property (@(posedge clk) disable iff (rst)
    stat.busy |-> !s_tready && !m_tvalid)
    else $error("ports open during rounds");

endmodule
`default_nettype wire

// ===== rtl/sha1md_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 compression unit
// Holds the 512-bit block as a byte shift register that doubles as the
// message schedule, runs one round per cycle for 80 rounds, then adds the
// working variables into the chaining value.
// ----------------------------------------------------------------------------
module sha1md_core (
  input  wire                         clk,
  input  wire                         rst,
  input  wire  sha1md_pkg::core_ctrl_t ctrl,
  output sha1md_pkg::core_stat_t      stat,
  output sha1md_pkg::chain_t          chain
);

  // Block / schedule: word t at [15], newest word at [0]
  logic [15:0][31:0] sched;
  logic [31:0]       a, b, c, d, e;
  logic [6:0]        rnd;
  logic              busy;
  logic              fin;

  logic [31:0] w_new;
  logic [31:0] sum;

  // Next schedule word and round sum
  always_comb begin
    w_new = sha1md_pkg::rotl(sched[2] ^ sched[7] ^ sched[13] ^ sched[15], 1);
    sum   = sha1md_pkg::rotl(a, 5) + sha1md_pkg::round_f(rnd, b, c, d) + e
            + sha1md_pkg::round_k(rnd) + sched[15];
  end

  // Load bytes, or advance the schedule during rounds
  always_ff @(posedge clk) begin
    if (ctrl.shift_en) begin
      sched <= {sched[15][23:0], sched[14:0], ctrl.shift_byte};
    end else if (busy) begin
      sched <= {sched[14:0], w_new};
    end
  end

  // Working variables
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
      e <= chain[4];
    end else if (busy) begin
      a <= sum;
      b <= a;
      c <= sha1md_pkg::rotl(b, 30);
      d <= c;
      e <= d;
    end
  end

  // Round sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      rnd  <= '0;
    end else begin
      fin <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        rnd  <= '0;
      end else if (busy) begin
        if (rnd == sha1md_pkg::LAST_ROUND) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
        rnd <= rnd + 7'd1;
      end
    end
  end

  // Chaining value: fold in the working variables after the last round
  always_ff @(posedge clk) begin
    if (rst || ctrl.chain_init) begin
      chain <= sha1md_pkg::chain_init_value();
    end else if (fin) begin
      chain[0] <= chain[0] + a;
      chain[1] <= chain[1] + b;
      chain[2] <= chain[2] + c;
      chain[3] <= chain[3] + d;
      chain[4] <= chain[4] + e;
    end
  end

  assign stat.busy = busy;
  assign stat.done = fin;

  // The sequencer never loads or restarts while rounds are running
  a_no_start_busy : assert property (@(posedge clk) disable iff (rst)
    ctrl.start |-> !busy && !fin)
    else $error("compression started while busy");

  a_no_shift_busy : assert property (@(posedge clk) disable iff (rst)
    ctrl.shift_en |-> !busy)
    else $error("block shifted during rounds");

  a_fin_after_last : assert property (@(posedge clk) disable iff (rst)
    fin |-> $past(busy) && $past(rnd) == sha1md_pkg::LAST_ROUND)
    else $error("finish without the last round");

endmodule
`default_nettype wire
